// File: design/phhc_pkg.sv
// ----------------------------------------------------------------------------
// phhc_pkg
// Shared types, constants and the microcode program of the heater hold
// controller.
// ----------------------------------------------------------------------------
package phhc_pkg;

    localparam int TEMP_W     = 13;
    localparam int ELAPSED_W  = 10;
    localparam int DUTY_BITS  = 8;
    localparam int STATUS_W   = 2;
    localparam int MS_W       = 26;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 8;
    localparam int REP_W      = 16;
    localparam int ESUM_W     = 32;
    localparam int SREP_W     = 17;
    localparam int SIMG_W     = 27;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;
    localparam int STEP_W     = 4;
    localparam int MUL_A_W    = 20;
    localparam int MUL_B_W    = 32;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int PID_W      = 10;
    localparam int X_W        = 18;

    // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for x < 2**X_W
    localparam logic [MUL_A_W-1:0] RECIP_1000  = MUL_A_W'(268436);
    localparam int                 RECIP_SHIFT = 28;

    localparam logic [GAIN_W-1:0]  RST_GAIN_P   = GAIN_W'(640);
    localparam logic [GAIN_W-1:0]  RST_GAIN_I   = GAIN_W'(0);
    localparam logic [GAIN_W-1:0]  RST_GAIN_D   = GAIN_W'(12800);
    localparam logic [LIMIT_W-1:0] RST_LIMIT    = LIMIT_W'(150);
    localparam logic [TEMP_W-1:0]  RST_TARGET   = TEMP_W'(1600);
    localparam logic [MS_W-1:0]    RST_HOLD     = MS_W'(600000);
    localparam logic [MS_W-1:0]    RST_IMG_INT  = MS_W'(0);
    localparam logic [REP_W-1:0]   RST_REP_INT  = REP_W'(1000);

    localparam logic [STEP_W-1:0]  STEP_FETCH = STEP_W'(0);
    localparam logic [STEP_W-1:0]  STEP_WRITE = STEP_W'(11);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P     = 3'd0,
        CFG_GAIN_I     = 3'd1,
        CFG_GAIN_D     = 3'd2,
        CFG_DUTY_LIMIT = 3'd3,
        CFG_TARGET     = 3'd4,
        CFG_HOLD       = 3'd5,
        CFG_IMG_INT    = 3'd6,
        CFG_REP_INT    = 3'd7
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_HEATING = 2'd0,
        ST_HOLDING = 2'd1,
        ST_DONE    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_FETCH  = 3'd1,
        OP_TIMERS = 3'd2,
        OP_INTEG  = 3'd3,
        OP_CLAMP  = 3'd4,
        OP_FLAGS  = 3'd5,
        OP_DUTY   = 3'd6,
        OP_WRITE  = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        A_GAIN_P = 3'd0,
        A_GAIN_I = 3'd1,
        A_GAIN_D = 3'd2,
        A_LIMIT  = 3'd3,
        A_RECIP  = 3'd4
    } t_asel;

    typedef enum logic [2:0] {
        B_ERR  = 3'd0,
        B_SUM  = 3'd1,
        B_DIFF = 3'd2,
        B_PID  = 3'd3,
        B_PROD = 3'd4
    } t_bsel;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } t_accop;

    typedef enum logic [2:0] {
        JC_NEXT     = 3'd0,
        JC_WAIT_IN  = 3'd1,
        JC_BYPASS   = 3'd2,
        JC_WAIT_OUT = 3'd3,
        JC_ALWAYS   = 3'd4
    } t_jcond;

    typedef struct packed {
        t_op               op;
        t_asel             a_sel;
        t_bsel             b_sel;
        logic              mul_en;
        t_accop            acc_op;
        t_jcond            jc;
        logic [STEP_W-1:0] target;
    } t_ucw;

    typedef struct packed {
        logic in_accept;
        logic bypass;
        logic out_free;
    } t_cond;

    function automatic t_ucw ucode_rom(input logic [STEP_W-1:0] step);
        t_ucw w;
        w = '0;
        unique case (step)
            4'd0: begin
                w.op = OP_FETCH;
                w.jc = JC_WAIT_IN;
            end
            4'd1: begin
                w.op     = OP_TIMERS;
                w.jc     = JC_BYPASS;
                w.target = STEP_WRITE;
            end
            4'd2: begin
                w.op = OP_INTEG;
            end
            4'd3: begin
                w.a_sel  = A_GAIN_P;
                w.b_sel  = B_ERR;
                w.mul_en = 1'b1;
            end
            4'd4: begin
                w.a_sel  = A_GAIN_I;
                w.b_sel  = B_SUM;
                w.mul_en = 1'b1;
                w.acc_op = ACC_LOAD;
            end
            4'd5: begin
                w.a_sel  = A_GAIN_D;
                w.b_sel  = B_DIFF;
                w.mul_en = 1'b1;
                w.acc_op = ACC_ADD;
            end
            4'd6: begin
                w.acc_op = ACC_ADD;
            end
            4'd7: begin
                w.op = OP_CLAMP;
            end
            4'd8: begin
                w.op     = OP_FLAGS;
                w.a_sel  = A_LIMIT;
                w.b_sel  = B_PID;
                w.mul_en = 1'b1;
            end
            4'd9: begin
                w.a_sel  = A_RECIP;
                w.b_sel  = B_PROD;
                w.mul_en = 1'b1;
            end
            4'd10: begin
                w.op = OP_DUTY;
            end
            4'd11: begin
                w.op     = OP_WRITE;
                w.jc     = JC_WAIT_OUT;
                w.target = STEP_FETCH;
            end
            default: begin
                w.jc     = JC_ALWAYS;
                w.target = STEP_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

// File: design/phhc_in_if.sv
// ----------------------------------------------------------------------------
// phhc_in_if
// Sample channel: start or control-sample transactions.
// ----------------------------------------------------------------------------
interface phhc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic signed [phhc_pkg::TEMP_W-1:0]   temperature;
    logic [phhc_pkg::ELAPSED_W-1:0]       elapsed_ms;

    modport source (output valid, output mode, output temperature, output elapsed_ms,
                    input ready);
    modport sink   (input valid, input mode, input temperature, input elapsed_ms,
                    output ready);
endinterface

// File: design/phhc_out_if.sv
// ----------------------------------------------------------------------------
// phhc_out_if
// Result channel: one transaction per accepted sample transaction.
// ----------------------------------------------------------------------------
interface phhc_out_if;
    logic                              valid;
    logic                              ready;
    logic [phhc_pkg::DUTY_BITS-1:0]    duty;
    logic [phhc_pkg::STATUS_W-1:0]     status;
    logic                              reached_now;
    logic                              image_trigger;
    logic                              led_on;
    logic                              report_due;
    logic [phhc_pkg::MS_W-1:0]         remaining_ms;

    modport source (output valid, output duty, output status, output reached_now,
                    output image_trigger, output led_on, output report_due,
                    output remaining_ms, input ready);
    modport sink   (input valid, input duty, input status, input reached_now,
                    input image_trigger, input led_on, input report_due,
                    input remaining_ms, output ready);
endinterface

// File: design/phhc_seq.sv
// ----------------------------------------------------------------------------
// phhc_seq
// Step counter and microcode ROM; emits one control word per cycle.
// ----------------------------------------------------------------------------
module phhc_seq import phhc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cond i_cond,
    output t_ucw  o_ucw
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    assign o_ucw = ucode_rom(r_step);

    always_comb begin
        unique case (o_ucw.jc)
            JC_NEXT:     n_step = r_step + 1'b1;
            JC_WAIT_IN:  n_step = i_cond.in_accept ? r_step + 1'b1 : r_step;
            JC_BYPASS:   n_step = i_cond.bypass ? o_ucw.target : r_step + 1'b1;
            JC_WAIT_OUT: n_step = i_cond.out_free ? o_ucw.target : r_step;
            JC_ALWAYS:   n_step = o_ucw.target;
            default:     n_step = STEP_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// File: design/pid_heater_hold_controller.sv
// ----------------------------------------------------------------------------
// pid_heater_hold_controller
// PID heater controller with setpoint hold timer, image and report timers.
// ----------------------------------------------------------------------------
// One sample transaction is taken at a time and yields one result transaction.
// A control sample runs the microcode program from the fetch step through the
// timer, integral, PID product, clamp, flag and duty steps to the result step;
// a start transaction, or a sample after the hold is done, goes from the timer
// step straight to the result step. The microcode program steps all
// products of the PID law and of the duty scaling through one shared 20x32
// multiplier. A finished result waits in the output register while the next
// transaction is fetched; the result step stalls while that register is full.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data.
// ----------------------------------------------------------------------------
module pid_heater_hold_controller import phhc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    phhc_in_if.sink               i_sample,
    phhc_out_if.source            o_result
);

    // configuration
    logic [GAIN_W-1:0]         r_gain_p, r_gain_i, r_gain_d;
    logic [LIMIT_W-1:0]        r_limit;
    logic signed [TEMP_W-1:0]  r_target;
    logic [MS_W-1:0]           r_hold, r_img_int;
    logic [REP_W-1:0]          r_rep_int;

    // loop state
    logic signed [TEMP_W-1:0]  r_last_err;
    logic signed [ESUM_W-1:0]  r_esum;
    logic                      r_reached, r_finished, r_led;
    logic [MS_W-1:0]           r_held;
    logic [SIMG_W-1:0]         r_since_img;
    logic [SREP_W-1:0]         r_since_rep;
    logic                      r_out_valid;

    // working registers
    logic                      r_mode;
    logic signed [TEMP_W-1:0]  r_temp;
    logic [ELAPSED_W-1:0]      r_elapsed;
    logic signed [TEMP_W-1:0]  r_e;
    logic signed [TEMP_W:0]    r_d;
    logic [MS_W:0]             r_held_full;
    logic signed [PROD_W-1:0]  r_prod, r_acc;
    logic [PID_W-1:0]          r_pid;
    logic                      r_pid_zero, r_pid_sat, r_kill;
    logic [DUTY_BITS-1:0]      r_duty;
    t_status                   r_status;
    logic                      r_rnow, r_img, r_rep;
    logic [MS_W-1:0]           r_remain;

    // output register
    logic [DUTY_BITS-1:0]      r_o_duty;
    logic [STATUS_W-1:0]       r_o_status;
    logic                      r_o_rnow, r_o_img, r_o_led, r_o_rep;
    logic [MS_W-1:0]           r_o_remain;

    t_ucw                      w_ucw;
    t_cond                     w_cond;
    logic                      w_in_accept, w_out_free;

    logic signed [TEMP_W:0]    w_e_raw;
    logic signed [TEMP_W-1:0]  w_e_sat;
    logic signed [TEMP_W:0]    w_d;
    logic signed [ESUM_W:0]    w_sum_raw;
    logic signed [ESUM_W-1:0]  w_sum_sat;
    logic [SREP_W:0]           w_rep_sum;
    logic [MS_W:0]             w_held_sum;
    logic [SIMG_W:0]           w_img_sum;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic                      w_reach_now, w_reached_new;
    logic [MS_W:0]             w_held_eff, w_hold_ext, w_hold_left;

    phhc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (w_cond),
        .o_ucw   (w_ucw)
    );

    assign i_sample.ready = (w_ucw.op == OP_FETCH);
    assign w_in_accept    = i_sample.valid && i_sample.ready;
    assign w_out_free     = !r_out_valid || o_result.ready;

    assign w_cond.in_accept = w_in_accept;
    assign w_cond.bypass    = !r_mode || r_finished;
    assign w_cond.out_free  = w_out_free;

    assign o_result.valid         = r_out_valid;
    assign o_result.duty          = r_o_duty;
    assign o_result.status        = r_o_status;
    assign o_result.reached_now   = r_o_rnow;
    assign o_result.image_trigger = r_o_img;
    assign o_result.led_on        = r_o_led;
    assign o_result.report_due    = r_o_rep;
    assign o_result.remaining_ms  = r_o_remain;

    // error, difference, integral and timer arithmetic
    always_comb begin
        w_e_raw = r_target - r_temp;
        if (w_e_raw > 14'sd4095) begin
            w_e_sat = 13'sh0FFF;
        end else if (w_e_raw < -14'sd4096) begin
            w_e_sat = 13'sh1000;
        end else begin
            w_e_sat = w_e_raw[TEMP_W-1:0];
        end

        w_d       = r_e - r_last_err;
        w_sum_raw = r_esum + r_e;
        unique case (w_sum_raw[ESUM_W:ESUM_W-1])
            2'b01:   w_sum_sat = {1'b0, {(ESUM_W-1){1'b1}}};
            2'b10:   w_sum_sat = {1'b1, {(ESUM_W-1){1'b0}}};
            default: w_sum_sat = w_sum_raw[ESUM_W-1:0];
        endcase

        w_rep_sum  = {1'b0, r_since_rep} + (SREP_W+1)'(r_elapsed);
        w_held_sum = {1'b0, r_held} + (MS_W+1)'(r_elapsed);
        w_img_sum  = {1'b0, r_since_img} + (SIMG_W+1)'(r_elapsed);
    end

    // shared multiplier
    always_comb begin
        unique case (w_ucw.a_sel)
            A_GAIN_P: w_mul_a = MUL_A_W'(r_gain_p);
            A_GAIN_I: w_mul_a = MUL_A_W'(r_gain_i);
            A_GAIN_D: w_mul_a = MUL_A_W'(r_gain_d);
            A_LIMIT:  w_mul_a = MUL_A_W'(r_limit);
            A_RECIP:  w_mul_a = RECIP_1000;
            default:  w_mul_a = '0;
        endcase
        unique case (w_ucw.b_sel)
            B_ERR:   w_mul_b = MUL_B_W'(r_e);
            B_SUM:   w_mul_b = r_esum;
            B_DIFF:  w_mul_b = MUL_B_W'(r_d);
            B_PID:   w_mul_b = MUL_B_W'(r_pid);
            B_PROD:  w_mul_b = MUL_B_W'(r_prod[X_W-1:0]);
            default: w_mul_b = '0;
        endcase
        w_prod = w_mul_a * w_mul_b;
    end

    // reach and hold-end checks
    always_comb begin
        w_reach_now   = !r_reached && (r_e > -13'sd16) && (r_e < 13'sd16);
        w_reached_new = r_reached || w_reach_now;
        w_held_eff    = w_reach_now ? '0 : r_held_full;
        w_hold_ext    = {1'b0, r_hold};
        w_hold_left   = w_hold_ext - w_held_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= RST_GAIN_P;
            r_gain_i    <= RST_GAIN_I;
            r_gain_d    <= RST_GAIN_D;
            r_limit     <= RST_LIMIT;
            r_target    <= RST_TARGET;
            r_hold      <= RST_HOLD;
            r_img_int   <= RST_IMG_INT;
            r_rep_int   <= RST_REP_INT;
            r_last_err  <= '0;
            r_esum      <= '0;
            r_reached   <= 1'b0;
            r_finished  <= 1'b0;
            r_led       <= 1'b0;
            r_held      <= '0;
            r_since_img <= '0;
            r_since_rep <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_GAIN_P:     r_gain_p  <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_I:     r_gain_i  <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_D:     r_gain_d  <= i_cfg_data[GAIN_W-1:0];
                    CFG_DUTY_LIMIT: r_limit   <= i_cfg_data[LIMIT_W-1:0];
                    CFG_TARGET:     r_target  <= i_cfg_data[TEMP_W-1:0];
                    CFG_HOLD:       r_hold    <= i_cfg_data[MS_W-1:0];
                    CFG_IMG_INT:    r_img_int <= i_cfg_data[MS_W-1:0];
                    CFG_REP_INT:    r_rep_int <= i_cfg_data[REP_W-1:0];
                    default: ;
                endcase
            end

            if (w_ucw.op == OP_WRITE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            case (w_ucw.op)
                OP_TIMERS: begin
                    if (!r_mode) begin
                        r_last_err  <= '0;
                        r_esum      <= '0;
                        r_reached   <= 1'b0;
                        r_finished  <= 1'b0;
                        r_held      <= '0;
                        r_since_img <= '0;
                        r_since_rep <= '0;
                    end else if (!r_finished) begin
                        r_since_rep <= w_rep_sum[SREP_W] ? '1 : w_rep_sum[SREP_W-1:0];
                        if (r_reached) begin
                            r_held      <= w_held_sum[MS_W] ? '1 : w_held_sum[MS_W-1:0];
                            r_since_img <= w_img_sum[SIMG_W] ? '1 : w_img_sum[SIMG_W-1:0];
                        end
                    end
                end
                OP_INTEG: begin
                    r_last_err <= r_e;
                    r_esum     <= w_sum_sat;
                end
                OP_FLAGS: begin
                    if (w_reach_now) begin
                        r_reached   <= 1'b1;
                        r_held      <= '0;
                        r_since_img <= '0;
                    end
                    if (r_rep_int == '0) begin
                        r_since_rep <= '0;
                    end else if (r_since_rep >= SREP_W'(r_rep_int)) begin
                        r_since_rep <= r_since_rep - SREP_W'(r_rep_int);
                    end
                    if (r_reached && r_img_int != '0 && r_since_img > SIMG_W'(r_img_int)) begin
                        r_led       <= 1'b1;
                        r_since_img <= r_since_img - SIMG_W'(r_img_int);
                    end
                    if (w_reached_new && w_held_eff > w_hold_ext) begin
                        r_finished <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ucw.mul_en) begin
            r_prod <= w_prod;
        end

        case (w_ucw.acc_op)
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            default: ;
        endcase

        case (w_ucw.op)
            OP_FETCH: begin
                if (w_in_accept) begin
                    r_mode    <= i_sample.mode;
                    r_temp    <= i_sample.temperature;
                    r_elapsed <= i_sample.elapsed_ms;
                end
            end
            OP_TIMERS: begin
                r_e         <= w_e_sat;
                r_held_full <= r_reached ? w_held_sum : {1'b0, r_held};
                // result of a start transaction or of a sample after done
                r_duty      <= '0;
                r_rnow      <= 1'b0;
                r_img       <= 1'b0;
                r_rep       <= 1'b0;
                r_status    <= r_mode ? ST_DONE : ST_HEATING;
                r_remain    <= r_mode ? '0 : r_hold;
            end
            OP_INTEG: begin
                r_d <= w_d;
            end
            OP_CLAMP: begin
                r_pid_zero <= r_acc < PROD_W'(256);
                r_pid_sat  <= r_acc >= PROD_W'(256000);
                r_pid      <= r_acc[PID_W+7:8];
            end
            OP_FLAGS: begin
                r_rnow <= w_reach_now;
                r_rep  <= (r_rep_int == '0) || (r_since_rep >= SREP_W'(r_rep_int));
                r_img  <= r_reached && r_img_int != '0 && r_since_img > SIMG_W'(r_img_int);
                r_kill <= w_reached_new && (w_held_eff > w_hold_ext);
                if (!w_reached_new) begin
                    r_status <= ST_HEATING;
                    r_remain <= r_hold;
                end else if (w_held_eff > w_hold_ext) begin
                    r_status <= ST_DONE;
                    r_remain <= '0;
                end else begin
                    r_status <= ST_HOLDING;
                    r_remain <= (w_held_eff >= w_hold_ext) ? '0 : w_hold_left[MS_W-1:0];
                end
            end
            OP_DUTY: begin
                if (r_kill || r_pid_zero) begin
                    r_duty <= '0;
                end else if (r_pid_sat) begin
                    r_duty <= DUTY_BITS'(r_limit);
                end else begin
                    r_duty <= r_prod[RECIP_SHIFT +: DUTY_BITS];
                end
            end
            OP_WRITE: begin
                if (w_out_free) begin
                    r_o_duty   <= r_duty;
                    r_o_status <= r_status;
                    r_o_rnow   <= r_rnow;
                    r_o_img    <= r_img;
                    r_o_led    <= r_led;
                    r_o_rep    <= r_rep;
                    r_o_remain <= r_remain;
                end
            end
            default: ;
        endcase
    end

endmodule
